/* hw/rtl/fsws_pkg.sv */
// ----------------------------------------------------------------------------
// fsws_pkg
// Shared types and constants for the frame stream window statistics block.
// ----------------------------------------------------------------------------
package fsws_pkg;

  localparam int unsigned FSWS_DEPTH     = 256;
  localparam int unsigned USEC_PER_SEC   = 1000000;
  localparam int unsigned WINDOW_RST     = 1000000;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned LAT_W   = 32;
  localparam int unsigned BYTES_W = 24;
  localparam int unsigned CTR_W   = 32;
  localparam int unsigned RATE_W  = 48;
  localparam int unsigned VAR_W   = 54;

  // input item kinds
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIM_RD,
    S_TRIM_CHK,
    S_SCAN,
    S_SETUP,
    S_MUL,
    S_DIV,
    S_STORE,
    S_OUT
  } fsws_state_t;

  // arithmetic steps of a query, in order
  typedef enum logic [2:0] {
    PH_NS2,
    PH_S1SQ,
    PH_NN,
    PH_VDIV,
    PH_RMUL,
    PH_RDIV,
    PH_MDIV
  } fsws_phase_t;

endpackage

/* hw/rtl/frame_stream_window_stats_top.sv */
// ----------------------------------------------------------------------------
// frame_stream_window_stats_top
// Sliding time window statistics over a frame stream, ring held in one RAM.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_ready  | kind, time, capture time, seq, bytes
// out_    | output    | out_valid/out_ready  | counters, latency, bitrate, variance
// cfg_    | input     | cfg_valid/cfg_ready  | window length in us
//
// A frame item runs the trim, with one RAM read and one compare per ring
// entry checked. A query adds the trim, a scan of N entries through the RAM
// read port and a shared shift-add / restoring-divide unit: 4 multiplies and
// 3 divides, plus setup and store steps. Reset is synchronous; the RAM holds
// no reset and is only read under count. A waiting result does not block new
// items; a query waits in S_OUT for it.
// ----------------------------------------------------------------------------
module frame_stream_window_stats_top
  import fsws_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = FSWS_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  logic [TIME_W-1:0]    in_time_us,
  input  logic [TIME_W-1:0]    in_captured_us,
  input  logic [CTR_W-1:0]     in_sequence_req,
  input  logic [BYTES_W-1:0]   in_encoded_bytes,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_window_us,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CTR_W-1:0]     out_frame_count,
  output logic [CTR_W-1:0]     out_drop_count,
  output logic [CTR_W-1:0]     out_error_count,
  output logic [BYTES_W-1:0]   out_newest_bytes,
  output logic [8:0]           out_window_count,
  output logic [LAT_W-1:0]     out_last_latency_us,
  output logic [LAT_W-1:0]     out_mean_latency_us,
  output logic [RATE_W-1:0]    out_bitrate_bps,
  output logic [VAR_W-1:0]     out_bits_variance
);

  localparam int unsigned IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned LSUM_W = LAT_W + CNT_W;
  localparam int unsigned S1_W   = BYTES_W + CNT_W;
  localparam int unsigned S2_W   = 2 * BYTES_W + CNT_W;
  localparam int unsigned DIV_W  = 2 * BYTES_W + 6 + 2 * CNT_W;
  localparam int unsigned DVS_W  = TIME_W;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);
  localparam int unsigned ENT_W  = TIME_W + LAT_W + BYTES_W;

  // ring storage: {time, latency, bytes}
  logic [ENT_W-1:0] mem [WINDOW_DEPTH];
  logic [ENT_W-1:0] rdata_r;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  logic [ENT_W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  logic [TIME_W-1:0]  rd_time;
  logic [LAT_W-1:0]   rd_lat;
  logic [BYTES_W-1:0] rd_bytes;
  assign rd_time  = rdata_r[ENT_W-1 -: TIME_W];
  assign rd_lat   = rdata_r[BYTES_W +: LAT_W];
  assign rd_bytes = rdata_r[BYTES_W-1:0];

  // control state
  fsws_state_t  state_r, state_nxt;
  fsws_phase_t  phase_r, phase_nxt;
  logic [IDX_W-1:0]  oldest_r, oldest_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CTR_W-1:0]  prev_seq_r, prev_seq_nxt;
  logic              seq_valid_r, seq_valid_nxt;
  logic [CTR_W-1:0]  frame_tot_r, frame_tot_nxt;
  logic [CTR_W-1:0]  drop_tot_r, drop_tot_nxt;
  logic [CTR_W-1:0]  err_tot_r, err_tot_nxt;
  logic [BYTES_W-1:0] newest_bytes_r, newest_bytes_nxt;
  logic [31:0]       window_r, window_nxt;
  logic              query_r, query_nxt;
  logic              rv_r, rv_nxt;
  logic              sv_r, sv_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [IDX_W-1:0]   scan_addr_r, scan_addr_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic [CNT_W-1:0]   rcv_r, rcv_nxt;
  logic [LSUM_W-1:0]  lsum_r, lsum_nxt;
  logic [S1_W-1:0]    s1_r, s1_nxt;
  logic [S2_W-1:0]    s2_r, s2_nxt;
  logic [2*BYTES_W-1:0] sq_r, sq_nxt;
  logic [TIME_W-1:0]  t0_r, t0_nxt, t1_r, t1_nxt;
  logic [LAT_W-1:0]   last_lat_r, last_lat_nxt;
  logic [DIV_W-1:0]   mul_a_r, mul_a_nxt;
  logic [S1_W-1:0]    mul_b_r, mul_b_nxt;
  logic [DIV_W-1:0]   prod_r, prod_nxt;
  logic [DIV_W-1:0]   tmp_r, tmp_nxt;
  logic [DVS_W-1:0]   rem_r, rem_nxt;
  logic [DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [VAR_W-1:0]   var_r, var_nxt;
  logic [RATE_W-1:0]  rate_r, rate_nxt;
  logic [LAT_W-1:0]   mean_r, mean_nxt;

  logic [CTR_W-1:0]   o_frames_r, o_frames_nxt, o_drop_r, o_drop_nxt, o_err_r, o_err_nxt;
  logic [BYTES_W-1:0] o_bytes_r, o_bytes_nxt;
  logic [8:0]         o_cnt_r, o_cnt_nxt;
  logic [LAT_W-1:0]   o_last_r, o_last_nxt, o_mean_r, o_mean_nxt;
  logic [RATE_W-1:0]  o_rate_r, o_rate_nxt;
  logic [VAR_W-1:0]   o_var_r, o_var_nxt;

  // handshakes
  logic in_acc;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // frame insert arithmetic
  logic               full;
  logic [IDX_W-1:0]   ins_oldest;
  logic [CNT_W-1:0]   ins_cnt;
  logic [SUM_W-1:0]   slot_sum;
  logic [IDX_W-1:0]   slot;
  logic [TIME_W-1:0]  lat_full;
  logic [LAT_W-1:0]   lat_sat;
  logic [CTR_W:0]     seq_next;
  logic               gap;
  logic [CTR_W-1:0]   gap_n;
  logic [CTR_W:0]     drop_sum;
  logic [CTR_W:0]     frame_sum;
  logic [CTR_W:0]     err_sum;

  always_comb begin
    full       = (count_r == CNT_W'(WINDOW_DEPTH));
    ins_oldest = full ? idx_inc(oldest_r) : oldest_r;
    ins_cnt    = full ? CNT_W'(WINDOW_DEPTH - 1) : count_r;
    slot_sum   = SUM_W'(ins_oldest) + SUM_W'(ins_cnt);
    slot       = (slot_sum >= SUM_W'(WINDOW_DEPTH)) ?
                 IDX_W'(slot_sum - SUM_W'(WINDOW_DEPTH)) : IDX_W'(slot_sum);
    lat_full   = (in_time_us > in_captured_us) ? in_time_us - in_captured_us : '0;
    lat_sat    = (|lat_full[TIME_W-1:LAT_W]) ? '1 : lat_full[LAT_W-1:0];
    seq_next   = {1'b0, prev_seq_r} + 1'b1;
    gap        = seq_valid_r && ({1'b0, in_sequence_req} > seq_next);
    gap_n      = in_sequence_req - prev_seq_r - 1'b1;
    drop_sum   = {1'b0, drop_tot_r} + {1'b0, gap_n};
    frame_sum  = {1'b0, frame_tot_r} + 1'b1;
    err_sum    = {1'b0, err_tot_r} + 1'b1;
  end

  // trim test on the entry just read
  logic              pop;
  logic [TIME_W-1:0] age;
  assign age = now_r - rd_time;
  assign pop = (now_r > rd_time) && (age > TIME_W'(window_r));

  logic trim_done;
  assign trim_done = ((state_r == S_TRIM_RD) && (count_r == '0)) ||
                     ((state_r == S_TRIM_CHK) && !pop);

  logic is_div;
  assign is_div = (phase_r == PH_VDIV) || (phase_r == PH_RDIV) || (phase_r == PH_MDIV);

  logic [TIME_W-1:0] elapsed;
  assign elapsed = (t1_r > t0_r) ? t1_r - t0_r : TIME_W'(USEC_PER_SEC);

  // divider step
  logic [DVS_W:0] rem_sh;
  logic           div_ge;
  logic [DVS_W:0] rem_sub;
  assign rem_sh  = {rem_r, prod_r[DIV_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_kind == KIND_FRAME || in_kind == KIND_QUERY)) begin
          state_nxt = S_TRIM_RD;
        end
      end
      S_TRIM_RD: begin
        if (count_r == '0) begin
          state_nxt = query_r ? S_OUT : S_IDLE;
        end else begin
          state_nxt = S_TRIM_CHK;
        end
      end
      S_TRIM_CHK: begin
        if (pop) begin
          state_nxt = S_TRIM_RD;
        end else begin
          state_nxt = query_r ? S_SCAN : S_IDLE;
        end
      end
      S_SCAN: begin
        if (iss_r == count_r && !rv_r && !sv_r) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: state_nxt = is_div ? S_DIV : S_MUL;
      S_MUL: begin
        if (step_r == STEP_W'(S1_W - 1)) begin
          state_nxt = S_STORE;
        end
      end
      S_DIV: begin
        if (step_r == STEP_W'(DIV_W - 1)) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: state_nxt = (phase_r == PH_MDIV) ? S_OUT : S_SETUP;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mem_we = 1'b0; mem_wa = slot;
    mem_wd = {in_time_us, lat_sat, in_encoded_bytes};
    mem_re = 1'b0; mem_ra = oldest_r;

    phase_nxt = phase_r; oldest_nxt = oldest_r; count_nxt = count_r;
    prev_seq_nxt = prev_seq_r; seq_valid_nxt = seq_valid_r;
    frame_tot_nxt = frame_tot_r; drop_tot_nxt = drop_tot_r; err_tot_nxt = err_tot_r;
    newest_bytes_nxt = newest_bytes_r; query_nxt = query_r;
    window_nxt = (cfg_valid && cfg_ready) ? cfg_window_us : window_r;
    now_nxt = now_r; scan_addr_nxt = scan_addr_r; iss_nxt = iss_r; rcv_nxt = rcv_r;
    lsum_nxt = lsum_r; s1_nxt = s1_r; s2_nxt = s2_r; sq_nxt = sq_r;
    t0_nxt = t0_r; t1_nxt = t1_r; last_lat_nxt = last_lat_r;
    rv_nxt = 1'b0; sv_nxt = 1'b0;
    mul_a_nxt = mul_a_r; mul_b_nxt = mul_b_r; prod_nxt = prod_r; tmp_nxt = tmp_r;
    rem_nxt = rem_r; dvs_nxt = dvs_r; step_nxt = step_r;
    var_nxt = var_r; rate_nxt = rate_r; mean_nxt = mean_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    o_frames_nxt = o_frames_r; o_drop_nxt = o_drop_r; o_err_nxt = o_err_r;
    o_bytes_nxt = o_bytes_r; o_cnt_nxt = o_cnt_r; o_last_nxt = o_last_r;
    o_mean_nxt = o_mean_r; o_rate_nxt = o_rate_r; o_var_nxt = o_var_r;

    // scan pipeline: RAM data, then square, then sum of squares
    if (rv_r) begin
      lsum_nxt = lsum_r + LSUM_W'(rd_lat);
      s1_nxt   = s1_r + S1_W'(rd_bytes);
      sq_nxt   = rd_bytes * rd_bytes;
      sv_nxt   = 1'b1;
      if (rcv_r == '0) begin
        t0_nxt = rd_time;
      end
      if (rcv_r == count_r - 1'b1) begin
        t1_nxt       = rd_time;
        last_lat_nxt = rd_lat;
      end
      rcv_nxt = rcv_r + 1'b1;
    end
    if (sv_r) begin
      s2_nxt = s2_r + S2_W'(sq_r);
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          now_nxt   = in_time_us;
          query_nxt = (in_kind == KIND_QUERY);
          case (in_kind)
            KIND_FRAME: begin
              if (gap) begin
                drop_tot_nxt = drop_sum[CTR_W] ? '1 : drop_sum[CTR_W-1:0];
              end
              prev_seq_nxt     = in_sequence_req;
              seq_valid_nxt    = 1'b1;
              frame_tot_nxt    = frame_sum[CTR_W] ? '1 : frame_sum[CTR_W-1:0];
              newest_bytes_nxt = in_encoded_bytes;
              oldest_nxt       = ins_oldest;
              count_nxt        = ins_cnt + 1'b1;
              mem_we           = 1'b1;
            end
            KIND_ERROR: begin
              err_tot_nxt = err_sum[CTR_W] ? '1 : err_sum[CTR_W-1:0];
            end
            default: ;
          endcase
        end
      end
      S_TRIM_RD: begin
        mem_re = (count_r != '0);
      end
      S_TRIM_CHK: begin
        if (pop) begin
          oldest_nxt = idx_inc(oldest_r);
          count_nxt  = count_r - 1'b1;
        end
      end
      S_SCAN: begin
        if (iss_r != count_r) begin
          mem_re        = 1'b1;
          mem_ra        = scan_addr_r;
          scan_addr_nxt = idx_inc(scan_addr_r);
          iss_nxt       = iss_r + 1'b1;
          rv_nxt        = 1'b1;
        end
        phase_nxt = PH_NS2;
      end
      S_SETUP: begin
        step_nxt = '0;
        rem_nxt  = '0;
        prod_nxt = '0;
        case (phase_r)
          PH_NS2: begin
            mul_a_nxt = DIV_W'(s2_r);
            mul_b_nxt = S1_W'(count_r);
          end
          PH_S1SQ: begin
            mul_a_nxt = DIV_W'(s1_r);
            mul_b_nxt = s1_r;
          end
          PH_NN: begin
            mul_a_nxt = DIV_W'(count_r);
            mul_b_nxt = S1_W'(count_r);
          end
          PH_VDIV: prod_nxt = tmp_r;
          PH_RMUL: begin
            mul_a_nxt = DIV_W'(s1_r) << 3;
            mul_b_nxt = S1_W'(USEC_PER_SEC);
          end
          PH_RDIV: begin
            prod_nxt = tmp_r;
            dvs_nxt  = elapsed;
          end
          PH_MDIV: begin
            prod_nxt = DIV_W'(lsum_r);
            dvs_nxt  = DVS_W'(count_r);
          end
          default: ;
        endcase
      end
      S_MUL: begin
        if (mul_b_r[0]) begin
          prod_nxt = prod_r + mul_a_r;
        end
        mul_a_nxt = mul_a_r << 1;
        mul_b_nxt = mul_b_r >> 1;
        step_nxt  = step_r + 1'b1;
      end
      S_DIV: begin
        rem_nxt  = div_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        prod_nxt = {prod_r[DIV_W-2:0], div_ge};
        step_nxt = step_r + 1'b1;
      end
      S_STORE: begin
        case (phase_r)
          PH_NS2: begin
            tmp_nxt = prod_r; phase_nxt = PH_S1SQ;
          end
          PH_S1SQ: begin
            tmp_nxt = (tmp_r - prod_r) << 6; phase_nxt = PH_NN;
          end
          PH_NN: begin
            dvs_nxt = prod_r[DVS_W-1:0]; phase_nxt = PH_VDIV;
          end
          PH_VDIV: begin
            var_nxt = prod_r[VAR_W-1:0]; phase_nxt = PH_RMUL;
          end
          PH_RMUL: begin
            tmp_nxt = prod_r; phase_nxt = PH_RDIV;
          end
          PH_RDIV: begin
            rate_nxt  = (|prod_r[DIV_W-1:RATE_W]) ? '1 : prod_r[RATE_W-1:0];
            phase_nxt = PH_MDIV;
          end
          PH_MDIV: mean_nxt = prod_r[LAT_W-1:0];
          default: ;
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_frames_nxt  = frame_tot_r;
          o_drop_nxt    = drop_tot_r;
          o_err_nxt     = err_tot_r;
          o_bytes_nxt   = newest_bytes_r;
          o_cnt_nxt     = 9'(count_r);
          if (count_r == '0) begin
            o_last_nxt = '0; o_mean_nxt = '0; o_rate_nxt = '0; o_var_nxt = '0;
          end else begin
            o_last_nxt = last_lat_r; o_mean_nxt = mean_r;
            o_rate_nxt = rate_r;     o_var_nxt  = var_r;
          end
        end
      end
      default: ;
    endcase

    // scan init once the query's trim has finished
    if (trim_done && query_r) begin
      scan_addr_nxt = oldest_r;
      iss_nxt = '0; rcv_nxt = '0;
      lsum_nxt = '0; s1_nxt = '0; s2_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      phase_r        <= PH_NS2;
      oldest_r       <= '0;
      count_r        <= '0;
      prev_seq_r     <= '0;
      seq_valid_r    <= 1'b0;
      frame_tot_r    <= '0;
      drop_tot_r     <= '0;
      err_tot_r      <= '0;
      newest_bytes_r <= '0;
      window_r       <= 32'(WINDOW_RST);
      query_r        <= 1'b0;
      rv_r           <= 1'b0;
      sv_r           <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      phase_r        <= phase_nxt;
      oldest_r       <= oldest_nxt;
      count_r        <= count_nxt;
      prev_seq_r     <= prev_seq_nxt;
      seq_valid_r    <= seq_valid_nxt;
      frame_tot_r    <= frame_tot_nxt;
      drop_tot_r     <= drop_tot_nxt;
      err_tot_r      <= err_tot_nxt;
      newest_bytes_r <= newest_bytes_nxt;
      window_r       <= window_nxt;
      query_r        <= query_nxt;
      rv_r           <= rv_nxt;
      sv_r           <= sv_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    scan_addr_r <= scan_addr_nxt;
    iss_r       <= iss_nxt;
    rcv_r       <= rcv_nxt;
    lsum_r      <= lsum_nxt;
    s1_r        <= s1_nxt;
    s2_r        <= s2_nxt;
    sq_r        <= sq_nxt;
    t0_r        <= t0_nxt;
    t1_r        <= t1_nxt;
    last_lat_r  <= last_lat_nxt;
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
    prod_r      <= prod_nxt;
    tmp_r       <= tmp_nxt;
    rem_r       <= rem_nxt;
    dvs_r       <= dvs_nxt;
    step_r      <= step_nxt;
    var_r       <= var_nxt;
    rate_r      <= rate_nxt;
    mean_r      <= mean_nxt;
    o_frames_r  <= o_frames_nxt;
    o_drop_r    <= o_drop_nxt;
    o_err_r     <= o_err_nxt;
    o_bytes_r   <= o_bytes_nxt;
    o_cnt_r     <= o_cnt_nxt;
    o_last_r    <= o_last_nxt;
    o_mean_r    <= o_mean_nxt;
    o_rate_r    <= o_rate_nxt;
    o_var_r     <= o_var_nxt;
  end

  assign out_frame_count        = o_frames_r;
  assign out_drop_count         = o_drop_r;
  assign out_error_count        = o_err_r;
  assign out_newest_bytes       = o_bytes_r;
  assign out_window_count       = o_cnt_r;
  assign out_last_latency_us    = o_last_r;
  assign out_mean_latency_us    = o_mean_r;
  assign out_bitrate_bps        = o_rate_r;
  assign out_bits_variance      = o_var_r;

endmodule
